// ----- hdl/sacl_pkg.sv -----
package sacl_pkg;

   localparam int CMD_W      = 2;
   localparam int OUTCOME_W  = 2;
   localparam int CNT_W      = 32;
   localparam int IN_ADDR_W  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int SET_BITS_W = 4;
   localparam int OFF_BITS_W = 6;
   localparam int WAYS_W     = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE       = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic commit;
      logic last;
   } sacl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_ignore;
      logic item_modify;
   } sacl_status_type;

endpackage

// ----- hdl/sacl_controller.sv -----
module sacl_controller
   import sacl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  sacl_status_type status,
   output sacl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !status.req_ignore) begin
               cmd.capture = 1'b1;
               pass_in     = 1'b0;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold the read row until the output slot frees up
            if (out_free) begin
               cmd.commit = 1'b1;
               cmd.last   = !(status.item_modify && !pass_ff);
               if (!cmd.last) begin
                  pass_in  = 1'b1;
                  state_in = ST_LOOKUP;
               end else begin
                  req_ready = 1'b1;
                  if (req_valid && !status.req_ignore) begin
                     cmd.capture = 1'b1;
                     pass_in     = 1'b0;
                     state_in    = ST_LOOKUP;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/sacl_datapath.sv -----
module sacl_datapath
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [IN_ADDR_W-1:0]  req_address,
   output logic [OUTCOME_W-1:0]  rsp_outcome,
   output logic [CNT_W-1:0]      rsp_hit_total,
   output logic [CNT_W-1:0]      rsp_miss_total,
   output logic [CNT_W-1:0]      rsp_eviction_total,
   output logic                  rsp_last_of_run,
   input  sacl_cmd_type          cmd,
   output sacl_status_type       status
);

   localparam int SIW      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 2 ** SIW;
   localparam int RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WW       = RW;
   localparam int NW_W     = 6;

   logic [SET_BITS_W-1:0] cfg_set_bits_ff;
   logic [OFF_BITS_W-1:0] cfg_offset_bits_ff;
   logic [WAYS_W-1:0]     cfg_ways_ff;

   logic [CMD_W-1:0]      cmd_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [SIW-1:0]        clr_ff;

   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0] evict_cnt_ff, evict_cnt_in;

   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [CNT_W-1:0]     out_hit_ff, out_miss_ff, out_evict_ff;
   logic                 out_last_ff;

   // set storage, one row per set
   logic [MAX_WAYS-1:0]                 valid_mem [NUM_SETS];
   logic [MAX_WAYS-1:0][RW-1:0]         rank_mem  [NUM_SETS];
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [NUM_SETS];

   logic [MAX_WAYS-1:0]                 rd_valid_ff;
   logic [MAX_WAYS-1:0][RW-1:0]         rd_rank_ff;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_ff;

   logic [MAX_WAYS-1:0]                 wr_valid;
   logic [MAX_WAYS-1:0][RW-1:0]         wr_rank;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tag;

   logic [4:0]            eff_sb;
   logic [6:0]            tag_shamt;
   logic [ADDR_WIDTH-1:0] set_shift;
   logic [SIW-1:0]        set_idx;
   logic [ADDR_WIDTH-1:0] tag;
   logic [NW_W-1:0]       nways;
   logic [MAX_WAYS-1:0]   in_use;

   logic          hit_f, fill_f;
   logic [WW-1:0] hit_w, fill_w, vict_w, sel_w;
   logic [RW-1:0] vict_r;
   logic [RW:0]   limit;

   // address split
   always_comb begin
      if ({1'b0, cfg_set_bits_ff} > 5'(MAX_SET_BITS)) begin
         eff_sb = 5'(MAX_SET_BITS);
      end else begin
         eff_sb = {1'b0, cfg_set_bits_ff};
      end
      tag_shamt = {2'b00, eff_sb} + {1'b0, cfg_offset_bits_ff};
      set_shift = addr_ff >> cfg_offset_bits_ff;
      tag       = addr_ff >> tag_shamt;
      for (int j = 0; j < SIW; j++) begin
         set_idx[j] = set_shift[j] && (5'(j) < eff_sb);
      end
      if (cfg_ways_ff == '0) begin
         nways = NW_W'(1);
      end else if ({2'b00, cfg_ways_ff} > NW_W'(MAX_WAYS)) begin
         nways = NW_W'(MAX_WAYS);
      end else begin
         nways = {2'b00, cfg_ways_ff};
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = NW_W'(i) < nways;
      end
   end

   // way selection: first hit, else first empty way, else oldest
   always_comb begin
      hit_f  = 1'b0;
      hit_w  = '0;
      fill_f = 1'b0;
      fill_w = '0;
      vict_w = '0;
      vict_r = rd_rank_ff[0];
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (!hit_f && in_use[i] && rd_valid_ff[i] && rd_tag_ff[i] == tag) begin
            hit_f = 1'b1;
            hit_w = WW'(i);
         end
         if (!fill_f && in_use[i] && !rd_valid_ff[i]) begin
            fill_f = 1'b1;
            fill_w = WW'(i);
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && rd_rank_ff[i] > vict_r) begin
            vict_r = rd_rank_ff[i];
            vict_w = WW'(i);
         end
      end
   end

   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (hit_f) begin
         sel_w      = hit_w;
         limit      = {1'b0, rd_rank_ff[hit_w]};
         outcome_in = OUT_HIT;
         if (hit_cnt_ff != CNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
      end else if (fill_f) begin
         sel_w      = fill_w;
         limit      = (RW + 1)'(MAX_WAYS);
         outcome_in = OUT_FILL;
         if (miss_cnt_ff != CNT_MAX) miss_cnt_in = miss_cnt_ff + 1'b1;
      end else begin
         sel_w      = vict_w;
         limit      = {1'b0, vict_r};
         outcome_in = OUT_EVICT;
         if (miss_cnt_ff != CNT_MAX) miss_cnt_in = miss_cnt_ff + 1'b1;
         if (evict_cnt_ff != CNT_MAX) evict_cnt_in = evict_cnt_ff + 1'b1;
      end
      wr_valid = rd_valid_ff;
      wr_rank  = rd_rank_ff;
      wr_tag   = rd_tag_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WW'(i) == sel_w) begin
            wr_valid[i] = 1'b1;
            wr_rank[i]  = '0;
            if (!hit_f) wr_tag[i] = tag;
         end else if (in_use[i] && rd_valid_ff[i] && {1'b0, rd_rank_ff[i]} < limit
                      && rd_rank_ff[i] < RW'(MAX_WAYS - 1)) begin
            wr_rank[i] = rd_rank_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         valid_mem[clr_ff] <= '0;
         rank_mem[clr_ff]  <= '0;
      end else if (cmd.commit) begin
         valid_mem[set_idx] <= wr_valid;
         rank_mem[set_idx]  <= wr_rank;
         tag_mem[set_idx]   <= wr_tag;
      end
      if (cmd.lookup) begin
         rd_valid_ff <= valid_mem[set_idx];
         rd_rank_ff  <= rank_mem[set_idx];
         rd_tag_ff   <= tag_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_set_bits_ff    <= '0;
         cfg_offset_bits_ff <= '0;
         cfg_ways_ff        <= WAYS_W'(1);
         clr_ff             <= '0;
         hit_cnt_ff         <= '0;
         miss_cnt_ff        <= '0;
         evict_cnt_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SET_INDEX_BITS:    cfg_set_bits_ff    <= csr_write_data[SET_BITS_W-1:0];
               CSR_BLOCK_OFFSET_BITS: cfg_offset_bits_ff <= csr_write_data[OFF_BITS_W-1:0];
               CSR_WAYS_IN_USE:       cfg_ways_ff        <= csr_write_data[WAYS_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.commit) begin
            hit_cnt_ff   <= hit_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            evict_cnt_ff <= evict_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address[ADDR_WIDTH-1:0];
      end
      if (cmd.commit) begin
         outcome_ff   <= outcome_in;
         out_hit_ff   <= hit_cnt_in;
         out_miss_ff  <= miss_cnt_in;
         out_evict_ff <= evict_cnt_in;
         out_last_ff  <= cmd.last;
      end
   end

   assign status.clear_last  = &clr_ff;
   assign status.req_ignore  = (req_command == CMD_UNKNOWN);
   assign status.item_modify = (cmd_ff == CMD_MODIFY);

   assign rsp_outcome        = outcome_ff;
   assign rsp_hit_total      = out_hit_ff;
   assign rsp_miss_total     = out_miss_ff;
   assign rsp_eviction_total = out_evict_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

// ----- hdl/set_assoc_cache_lru_tag_sim.sv -----
// Flow: an accepted item is read in a lookup step and written back in an update step, and its
//   result is registered at that write-back; a modify runs a second lookup and update pass.
// The update step waits until the last result has been taken. Each pass is one row read, then one
//   row write-back; a new item is taken only once the last pass of the current item writes back.
// Reset: synchronous; counters, configuration and control state clear, then a clearing pass
//   steps through every set and empties it while req_ready stays low.
module set_assoc_cache_lru_tag_sim
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [IN_ADDR_W-1:0]  req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUTCOME_W-1:0]  rsp_outcome,
   output logic [CNT_W-1:0]      rsp_hit_total,
   output logic [CNT_W-1:0]      rsp_miss_total,
   output logic [CNT_W-1:0]      rsp_eviction_total,
   output logic                  rsp_last_of_run
);

   sacl_cmd_type    cmd;
   sacl_status_type status;

   sacl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sacl_datapath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_command        (req_command),
      .req_address        (req_address),
      .rsp_outcome        (rsp_outcome),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_last_of_run    (rsp_last_of_run),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ----- hdl/sacl_checker.sv -----
module sacl_checker
   import sacl_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUTCOME_W-1:0] rsp_outcome,
   input logic [CNT_W-1:0]     rsp_hit_total,
   input logic [CNT_W-1:0]     rsp_miss_total,
   input logic [CNT_W-1:0]     rsp_eviction_total,
   input logic                 rsp_last_of_run
);

   // the clearing pass follows reset: nothing moves on either side
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("transfer possible right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_hit_total) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome == OUT_HIT || rsp_outcome == OUT_FILL
         || rsp_outcome == OUT_EVICT)
      else $error("undefined outcome code");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_HIT |-> rsp_hit_total != '0)
      else $error("hit shown with zero hit total");

   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_EVICT |->
         rsp_eviction_total != '0 && rsp_eviction_total <= rsp_miss_total)
      else $error("eviction total inconsistent");

endmodule

bind set_assoc_cache_lru_tag_sim sacl_checker u_sacl_checker (.*);

// ----- test/sacl_lru_checker.sv -----
`timescale 1ns / 100ps

module sacl_lru_checker
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [IN_ADDR_W-1:0]  req_address,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [OUTCOME_W-1:0]  rsp_outcome,
   input  logic [CNT_W-1:0]      rsp_hit_total,
   input  logic [CNT_W-1:0]      rsp_miss_total,
   input  logic [CNT_W-1:0]      rsp_eviction_total,
   input  logic                  rsp_last_of_run,
   output int                    error_count,
   output int                    pending_count,
   output int                    checked_count
);

   localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [CNT_W-1:0]     hit_total;
      logic [CNT_W-1:0]     miss_total;
      logic [CNT_W-1:0]     eviction_total;
      logic                 last_of_run;
   } access_result_type;

   access_result_type access_results_q[$];

   logic                 line_valid_q [NUM_LINES];
   logic [IN_ADDR_W-1:0] line_tag_q   [NUM_LINES];
   logic [RANK_W-1:0]    line_rank_q  [NUM_LINES];
   logic [CNT_W-1:0]     hits;
   logic [CNT_W-1:0]     misses;
   logic [CNT_W-1:0]     evictions;
   logic [SET_BITS_W-1:0] cfg_set_bits;
   logic [OFF_BITS_W-1:0] cfg_offset_bits;
   logic [WAYS_W-1:0]     cfg_ways;
   int errors;
   int checked;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Make way w the newest; valid ways younger than limit age by one, capped at the oldest rank.
   function automatic void refresh_rank(input int base, input int nways, input int w,
                                        input int limit);
      int k;
      for (int i = 0; i < nways; i++) begin
         k = base + i;
         if (i != w && line_valid_q[k] && int'(line_rank_q[k]) < limit &&
             int'(line_rank_q[k]) < MAX_WAYS - 1)
            line_rank_q[k] = line_rank_q[k] + 1'b1;
      end
      line_rank_q[base + w] = '0;
   endfunction

   function automatic logic [OUTCOME_W-1:0] lookup_and_replace(
      input logic [IN_ADDR_W-1:0] addr);
      int sb, ob, nways, base, victim, vrank;
      logic [IN_ADDR_W-1:0] set_sel, tag_val;
      sb    = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
      ob    = int'(cfg_offset_bits);
      nways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
      addr    = addr & ({IN_ADDR_W{1'b1}} >> (IN_ADDR_W - ADDR_WIDTH));
      set_sel = (addr >> ob) & ((64'd1 << sb) - 1);
      tag_val = '0;
      if (sb + ob < IN_ADDR_W)
         tag_val = addr >> (sb + ob);
      base = int'(set_sel) * MAX_WAYS;

      for (int i = 0; i < nways; i++) begin
         if (line_valid_q[base + i] && line_tag_q[base + i] == tag_val) begin
            hits = bump(hits);
            refresh_rank(base, nways, i, int'(line_rank_q[base + i]));
            return OUT_HIT;
         end
      end

      misses = bump(misses);
      for (int i = 0; i < nways; i++) begin
         if (!line_valid_q[base + i]) begin
            line_valid_q[base + i] = 1'b1;
            line_tag_q[base + i]   = tag_val;
            refresh_rank(base, nways, i, MAX_WAYS);
            return OUT_FILL;
         end
      end

      // Oldest way goes; the lowest way wins a tie.
      evictions = bump(evictions);
      victim = 0;
      vrank  = int'(line_rank_q[base]);
      for (int i = 1; i < nways; i++) begin
         if (int'(line_rank_q[base + i]) > vrank) begin
            vrank  = int'(line_rank_q[base + i]);
            victim = i;
         end
      end
      line_tag_q[base + victim] = tag_val;
      refresh_rank(base, nways, victim, vrank);
      return OUT_EVICT;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      access_result_type r;
      int n;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            line_valid_q[i] = 1'b0;
            line_tag_q[i]   = '0;
            line_rank_q[i]  = '0;
         end
         hits            = '0;
         misses          = '0;
         evictions       = '0;
         cfg_set_bits    = '0;
         cfg_offset_bits = '0;
         cfg_ways        = WAYS_W'(1);
         access_results_q.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (access_results_q.size() == 0) begin
               $error("result transfer with no access outstanding");
               errors++;
            end else begin
               r = access_results_q.pop_front();
               check_field("outcome", 64'(r.outcome), 64'(rsp_outcome));
               check_field("hit_total", 64'(r.hit_total), 64'(rsp_hit_total));
               check_field("miss_total", 64'(r.miss_total), 64'(rsp_miss_total));
               check_field("eviction_total", 64'(r.eviction_total),
                           64'(rsp_eviction_total));
               check_field("last_of_run", 64'(r.last_of_run), 64'(rsp_last_of_run));
               checked++;
            end
         end

         if (csr_write_enable) begin
            case (csr_index)
               CSR_SET_INDEX_BITS:    cfg_set_bits    = csr_write_data[SET_BITS_W-1:0];
               CSR_BLOCK_OFFSET_BITS: cfg_offset_bits = csr_write_data[OFF_BITS_W-1:0];
               CSR_WAYS_IN_USE:       cfg_ways        = csr_write_data[WAYS_W-1:0];
               default: ;
            endcase
         end

         // An unknown command is dropped without a result.
         if (req_valid && req_ready && req_command != CMD_UNKNOWN) begin
            n = (req_command == CMD_MODIFY) ? 2 : 1;
            for (int k = 0; k < n; k++) begin
               r.outcome        = lookup_and_replace(req_address);
               r.hit_total      = hits;
               r.miss_total     = misses;
               r.eviction_total = evictions;
               r.last_of_run    = (k == n - 1);
               access_results_q.push_back(r);
            end
         end
      end
      error_count   <= errors;
      pending_count <= access_results_q.size();
      checked_count <= checked;
   end

endmodule

// ----- test/set_assoc_cache_lru_tag_sim_tb.sv -----
`timescale 1ns / 100ps

module set_assoc_cache_lru_tag_sim_tb;
   import sacl_pkg::*;

   localparam int MAX_SET_BITS   = 8;
   localparam int MAX_WAYS       = 8;
   localparam int ADDR_WIDTH     = 64;
   localparam int RANDOM_ITEMS   = 700;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SET_INDEX_BITS;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = CMD_LOAD;
   logic [IN_ADDR_W-1:0]  req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OUTCOME_W-1:0]  rsp_outcome;
   logic [CNT_W-1:0]      rsp_hit_total;
   logic [CNT_W-1:0]      rsp_miss_total;
   logic [CNT_W-1:0]      rsp_eviction_total;
   logic                  rsp_last_of_run;

   int error_count;
   int pending_count;
   int checked_count;
   int sent_items = 0;
   int geometry_count = 0;
   int req_burst_left = 0;
   int idle_cycles = 0;
   logic [SET_BITS_W-1:0] cur_set_bits = '0;
   logic [OFF_BITS_W-1:0] cur_offset_bits = '0;

   set_assoc_cache_lru_tag_sim #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_top (.*);

   sacl_lru_checker #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // End the run if nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL set_assoc_cache_lru_tag_sim");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Result side: random stall before each result, with stretches of none.
   initial begin
      int stall;
      int burst_left;
      burst_left = 0;
      forever begin
         if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
               burst_left = $urandom_range(8, 40);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [IN_ADDR_W-1:0] addr);
      int gap;
      if (req_burst_left > 0) begin
         gap = 0;
         req_burst_left--;
      end else begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0)
            req_burst_left = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd != CMD_UNKNOWN)
         sent_items++;
   endtask

   // Hold off until every expected result is in, then let the design settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [SET_BITS_W-1:0] sb,
                               input logic [OFF_BITS_W-1:0] ob,
                               input logic [WAYS_W-1:0] ways);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SET_INDEX_BITS;
      csr_write_data   <= CSR_DATA_W'(sb);
      @(posedge clock);
      csr_index        <= CSR_BLOCK_OFFSET_BITS;
      csr_write_data   <= CSR_DATA_W'(ob);
      @(posedge clock);
      csr_index        <= CSR_WAYS_IN_USE;
      csr_write_data   <= CSR_DATA_W'(ways);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_set_bits    = sb;
      cur_offset_bits = ob;
      geometry_count++;
   endtask

   function automatic logic [IN_ADDR_W-1:0] make_address(input logic [63:0] tag,
                                                         input logic [63:0] set_sel,
                                                         input logic [63:0] offset);
      int sb, ob;
      logic [IN_ADDR_W-1:0] a;
      sb = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
      ob = int'(cur_offset_bits);
      a  = offset & ((64'd1 << ob) - 1);
      a  = a | ((set_sel & ((64'd1 << sb) - 1)) << ob);
      if (sb + ob < IN_ADDR_W)
         a = a | (tag << (sb + ob));
      return a;
   endfunction

   initial begin
      logic [CMD_W-1:0]      cmd;
      logic [SET_BITS_W-1:0] sb;
      logic [OFF_BITS_W-1:0] ob;
      logic [WAYS_W-1:0]     ways;
      logic [63:0]           tag_pool [16];
      logic [63:0]           set_pool [4];
      int phase_len, done, pick, n_sets, n_tags, eff_ways;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Two-way sets: fill, hit, eviction, modify, ignored command, address extremes.
      set_geometry(2, 4, 2);
      send_access(CMD_LOAD, 64'h0);
      send_access(CMD_LOAD, 64'h0);
      send_access(CMD_STORE, 64'h40);
      send_access(CMD_MODIFY, 64'h80);
      send_access(CMD_LOAD, 64'h0);
      send_access(CMD_UNKNOWN, 64'h0);
      send_access(CMD_LOAD, '1);
      send_access(CMD_STORE, '1);
      send_access(CMD_MODIFY, 64'h10);
      drain_results();

      // Set bits past the maximum, tag shifted out entirely, zero ways.
      set_geometry(15, 63, 0);
      send_access(CMD_LOAD, '1);
      send_access(CMD_LOAD, 64'h0);
      send_access(CMD_MODIFY, 64'h5);
      drain_results();

      // Way count past the maximum; overflow one set to force LRU evictions.
      set_geometry(8, 0, 15);
      for (int k = 1; k <= 9; k++)
         send_access(CMD_LOAD, 64'(k) << 8);
      send_access(CMD_MODIFY, 64'h100);
      drain_results();

      while (sent_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       sb = 0;
            1:       sb = SET_BITS_W'(MAX_SET_BITS);
            2:       sb = SET_BITS_W'($urandom_range(MAX_SET_BITS + 1, 15));
            default: sb = SET_BITS_W'($urandom_range(0, MAX_SET_BITS));
         endcase
         case ($urandom_range(0, 5))
            0:       ob = 0;
            1:       ob = 63;
            2:       ob = OFF_BITS_W'($urandom_range(32, 63));
            default: ob = OFF_BITS_W'($urandom_range(0, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       ways = 0;
            1:       ways = 1;
            2:       ways = WAYS_W'(MAX_WAYS);
            3:       ways = WAYS_W'($urandom_range(MAX_WAYS + 1, 15));
            default: ways = WAYS_W'($urandom_range(2, MAX_WAYS - 1));
         endcase
         set_geometry(sb, ob, ways);

         // A few more tags than ways over a few sets keeps hits and evictions coming.
         eff_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
         n_tags   = eff_ways + $urandom_range(0, 3);
         n_sets   = $urandom_range(1, 4);
         foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
         foreach (set_pool[i]) set_pool[i] = {$urandom, $urandom};

         phase_len = $urandom_range(30, 80);
         done = 0;
         while (done < phase_len) begin
            pick = $urandom_range(0, 99);
            cmd  = CMD_W'($urandom_range(CMD_LOAD, CMD_MODIFY));
            if (pick < 4)
               send_access(CMD_UNKNOWN, {$urandom, $urandom});
            else begin
               if (pick < 14)
                  send_access(cmd, {$urandom, $urandom});
               else
                  send_access(cmd, make_address(tag_pool[$urandom_range(0, n_tags - 1)],
                                                set_pool[$urandom_range(0, n_sets - 1)],
                                                {$urandom, $urandom}));
               done++;
            end
         end
         drain_results();
      end

      $display("Checked %0d cache results from %0d accesses over %0d cache geometries",
               checked_count, sent_items, geometry_count);
      if (error_count == 0 && pending_count == 0)
         $display("PASS set_assoc_cache_lru_tag_sim");
      else
         $display("FAIL set_assoc_cache_lru_tag_sim");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/sacl_pkg.sv
hdl/sacl_controller.sv
hdl/sacl_datapath.sv
hdl/set_assoc_cache_lru_tag_sim.sv
hdl/sacl_checker.sv
test/sacl_lru_checker.sv
test/set_assoc_cache_lru_tag_sim_tb.sv
